// ----- sv/aeg_pkg.sv -----
// ----------------------------------------------------------------------------
// aeg_pkg
// Shared types and constants of the ADSR envelope gain block: item formats,
// configuration register indexes, phase codes and the stage formats that
// travel between the front end, the divider and the output stage.
// ----------------------------------------------------------------------------
package aeg_pkg;

    // Field widths
    localparam int TIME_W     = 32;
    localparam int LEN_W      = 24;
    localparam int GAIN_W     = 16;
    localparam int PHASE_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // One quotient bit per divider stage; the quotient is a Q0.16 gain
    localparam int DIV_STEPS  = GAIN_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_LENGTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_LEVEL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_LENGTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN_LEVEL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_LENGTH = 3'd4;

    // Register reset values
    localparam logic [LEN_W-1:0]  RST_LENGTH = '0;
    localparam logic [GAIN_W-1:0] RST_LEVEL  = '1;

    // Envelope phase codes
    typedef enum logic [PHASE_W-1:0] {
        PH_WAIT    = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_DECAY   = 3'd2,
        PH_SUSTAIN = 3'd3,
        PH_RELEASE = 3'd4,
        PH_DONE    = 3'd5
    } t_phase;

    // Configuration register file
    typedef struct packed {
        logic [LEN_W-1:0]  attack_length;
        logic [GAIN_W-1:0] attack_level;
        logic [LEN_W-1:0]  decay_length;
        logic [GAIN_W-1:0] sustain_level;
        logic [LEN_W-1:0]  release_length;
    } t_cfg;

    // Input item
    typedef struct packed {
        logic signed [TIME_W-1:0] elapsed;
        logic                     released;
        logic signed [TIME_W-1:0] release_moment;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [GAIN_W-1:0]  gain;
        logic [PHASE_W-1:0] phase;
    } t_out_item;

    // Ramp operands: gain = base +/- mult * mcand / divisor
    typedef struct packed {
        logic [GAIN_W-1:0] mult;
        logic [LEN_W-1:0]  mcand;
        logic [LEN_W-1:0]  divisor;
        logic [GAIN_W-1:0] base;
        logic              sub;
        t_phase            phase;
    } t_mul_item;

    // Divider state: partial remainder, and a shift register that feeds
    // dividend bits out at the top and takes quotient bits in at the bottom
    typedef struct packed {
        logic [LEN_W-1:0]  rem;
        logic [GAIN_W-1:0] lq;
        logic [LEN_W-1:0]  divisor;
        logic [GAIN_W-1:0] base;
        logic              sub;
        t_phase            phase;
    } t_div_item;

endpackage

// ----- sv/aeg_front.sv -----
// ----------------------------------------------------------------------------
// aeg_front
// Three register stages: time differences, phase selection with ramp
// operands, and the ramp product that seeds the divider.
// ----------------------------------------------------------------------------
module aeg_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  aeg_pkg::t_cfg      i_cfg,
    input  logic               i_valid,
    output logic               o_stall,
    input  aeg_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output aeg_pkg::t_div_item o_item
);

    typedef struct packed {
        logic                      t_neg;
        logic [aeg_pkg::LEN_W-1:0] t_low;
        logic                      released;
        logic [aeg_pkg::TIME_W:0]  d;    // elapsed - attack_length
        logic [aeg_pkg::TIME_W:0]  r;    // elapsed - release_moment
    } t_cls_item;

    logic               r_a_valid, r_b_valid, r_c_valid;
    logic               en_a, en_b, en_c;
    t_cls_item          r_a, n_a;
    aeg_pkg::t_mul_item r_b, n_b;
    aeg_pkg::t_div_item r_c, n_c;

    logic                         d_neg, d_lt_len, r_neg, r_lt_len, drop_neg;
    logic [aeg_pkg::GAIN_W:0]     drop;
    logic [aeg_pkg::GAIN_W-1:0]   drop_mag;
    logic [aeg_pkg::TIME_W+7:0]   prod;

    // Stage enables: a stage loads when empty or when its item moves on
    assign en_c    = ~r_c_valid | ~i_stall;
    assign en_b    = ~r_b_valid | en_c;
    assign en_a    = ~r_a_valid | en_b;
    assign o_stall = ~en_a;

    // Stage A: form both time differences
    always_comb begin
        n_a.t_neg    = i_item.elapsed[aeg_pkg::TIME_W-1];
        n_a.t_low    = i_item.elapsed[aeg_pkg::LEN_W-1:0];
        n_a.released = i_item.released;
        n_a.d        = {i_item.elapsed[aeg_pkg::TIME_W-1], i_item.elapsed}
                     - {{(aeg_pkg::TIME_W+1-aeg_pkg::LEN_W){1'b0}},
                        i_cfg.attack_length};
        n_a.r        = {i_item.elapsed[aeg_pkg::TIME_W-1], i_item.elapsed}
                     - {i_item.release_moment[aeg_pkg::TIME_W-1],
                        i_item.release_moment};
    end

    // Stage B: pick the phase and the ramp operands
    always_comb begin
        d_neg    = r_a.d[aeg_pkg::TIME_W];
        r_neg    = r_a.r[aeg_pkg::TIME_W];
        d_lt_len = $signed(r_a.d) < $signed({{(aeg_pkg::TIME_W+1-aeg_pkg::LEN_W){1'b0}},
                                             i_cfg.decay_length});
        r_lt_len = $signed(r_a.r) < $signed({{(aeg_pkg::TIME_W+1-aeg_pkg::LEN_W){1'b0}},
                                             i_cfg.release_length});
        drop     = {1'b0, i_cfg.attack_level} - {1'b0, i_cfg.sustain_level};
        drop_neg = drop[aeg_pkg::GAIN_W];
        drop_mag = drop_neg ? (i_cfg.sustain_level - i_cfg.attack_level)
                            : drop[aeg_pkg::GAIN_W-1:0];

        // Flat phases: zero product over a full-scale divisor gives zero
        n_b.mult    = '0;
        n_b.mcand   = '0;
        n_b.divisor = '1;
        n_b.base    = '0;
        n_b.sub     = 1'b0;
        n_b.phase   = aeg_pkg::PH_WAIT;

        if (r_a.t_neg) begin
            n_b.phase = aeg_pkg::PH_WAIT;
        end else if (d_neg) begin
            n_b.mult    = i_cfg.attack_level;
            n_b.mcand   = r_a.t_low;
            n_b.divisor = i_cfg.attack_length;
            n_b.phase   = aeg_pkg::PH_ATTACK;
        end else if (d_lt_len) begin
            // Downward or upward ramp; magnitude divided, sign applied later
            n_b.mult    = drop_mag;
            n_b.mcand   = r_a.d[aeg_pkg::LEN_W-1:0];
            n_b.divisor = i_cfg.decay_length;
            n_b.base    = i_cfg.attack_level;
            n_b.sub     = ~drop_neg;
            n_b.phase   = aeg_pkg::PH_DECAY;
        end else if (!r_a.released || r_neg) begin
            n_b.base    = i_cfg.sustain_level;
            n_b.phase   = aeg_pkg::PH_SUSTAIN;
        end else if (r_lt_len) begin
            n_b.mult    = i_cfg.sustain_level;
            n_b.mcand   = r_a.r[aeg_pkg::LEN_W-1:0];
            n_b.divisor = i_cfg.release_length;
            n_b.base    = i_cfg.sustain_level;
            n_b.sub     = 1'b1;
            n_b.phase   = aeg_pkg::PH_RELEASE;
        end else begin
            n_b.phase   = aeg_pkg::PH_DONE;
        end
    end

    // Stage C: ramp product; its top bits are the first partial remainder
    always_comb begin
        prod = {{aeg_pkg::LEN_W{1'b0}}, r_b.mult} * {{aeg_pkg::GAIN_W{1'b0}}, r_b.mcand};
        n_c.rem     = prod[aeg_pkg::LEN_W+aeg_pkg::GAIN_W-1:aeg_pkg::GAIN_W];
        n_c.lq      = prod[aeg_pkg::GAIN_W-1:0];
        n_c.divisor = r_b.divisor;
        n_c.base    = r_b.base;
        n_c.sub     = r_b.sub;
        n_c.phase   = r_b.phase;
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (en_a) r_a_valid <= i_valid;
            if (en_b) r_b_valid <= r_a_valid;
            if (en_c) r_c_valid <= r_b_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (en_a && i_valid)   r_a <= n_a;
        if (en_b && r_a_valid) r_b <= n_b;
        if (en_c && r_b_valid) r_c <= n_c;
    end

    assign o_valid = r_c_valid;
    assign o_item  = r_c;

endmodule

// ----- sv/aeg_divider.sv -----
// ----------------------------------------------------------------------------
// aeg_divider
// Pipelined restoring divider: one quotient bit per register stage. The
// first partial remainder is below the divisor, so the quotient fits the
// gain width.
// ----------------------------------------------------------------------------
module aeg_divider (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  aeg_pkg::t_div_item i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output aeg_pkg::t_div_item o_item
);

    logic               r_valid [aeg_pkg::DIV_STEPS];
    aeg_pkg::t_div_item r_item  [aeg_pkg::DIV_STEPS];
    logic               s_vin   [aeg_pkg::DIV_STEPS];
    aeg_pkg::t_div_item s_in    [aeg_pkg::DIV_STEPS];
    aeg_pkg::t_div_item n_item  [aeg_pkg::DIV_STEPS];
    logic               s_en    [aeg_pkg::DIV_STEPS];
    logic               s_down  [aeg_pkg::DIV_STEPS];

    for (genvar k = 0; k < aeg_pkg::DIV_STEPS; k++) begin : g_step
        logic [aeg_pkg::LEN_W+1:0] trial;
        logic                      qbit;

        // Chain the stages
        if (k == 0) begin : g_first
            assign s_vin[k] = i_valid;
            assign s_in[k]  = i_item;
        end else begin : g_next
            assign s_vin[k] = r_valid[k-1];
            assign s_in[k]  = r_item[k-1];
        end

        if (k == aeg_pkg::DIV_STEPS - 1) begin : g_last
            assign s_down[k] = i_stall;
        end else begin : g_inner
            assign s_down[k] = ~s_en[k+1];
        end

        assign s_en[k] = ~r_valid[k] | ~s_down[k];

        // Bring down one dividend bit, subtract the divisor where it fits
        always_comb begin
            trial = {1'b0, s_in[k].rem, s_in[k].lq[aeg_pkg::GAIN_W-1]}
                  - {2'b00, s_in[k].divisor};
            qbit  = ~trial[aeg_pkg::LEN_W+1];
            n_item[k]     = s_in[k];
            n_item[k].rem = qbit ? trial[aeg_pkg::LEN_W-1:0]
                                 : {s_in[k].rem[aeg_pkg::LEN_W-2:0],
                                    s_in[k].lq[aeg_pkg::GAIN_W-1]};
            n_item[k].lq  = {s_in[k].lq[aeg_pkg::GAIN_W-2:0], qbit};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (s_en[k]) begin
                r_valid[k] <= s_vin[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (s_en[k] && s_vin[k]) begin
                r_item[k] <= n_item[k];
            end
        end
    end

    assign o_stall = ~s_en[0];
    assign o_valid = r_valid[aeg_pkg::DIV_STEPS-1];
    assign o_item  = r_item[aeg_pkg::DIV_STEPS-1];

endmodule

// ----- sv/aeg_output.sv -----
// ----------------------------------------------------------------------------
// aeg_output
// Output stage: apply the ramp quotient to the phase's base gain and hold
// the result item until it is taken.
// ----------------------------------------------------------------------------
module aeg_output (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  aeg_pkg::t_div_item i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output aeg_pkg::t_out_item o_item
);

    logic               r_valid;
    logic               en;
    aeg_pkg::t_out_item r_item, n_item;

    assign en      = ~r_valid | ~i_stall;
    assign o_stall = ~en;

    // Ramp result stays between its end points, so no clamp is needed
    always_comb begin
        n_item.gain  = i_item.sub ? (i_item.base - i_item.lq) : (i_item.base + i_item.lq);
        n_item.phase = i_item.phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ----- sv/adsr_envelope_gain.sv -----
// ----------------------------------------------------------------------------
// adsr_envelope_gain
// Linear ADSR envelope gain with phase code, one result item per input item.
// ----------------------------------------------------------------------------
// Takes one item per clock while no stall holds the pipeline and returns one
// result per item, in order, through three front stages (time differences,
// phase select, ramp product), sixteen divider stages that each resolve one
// bit of the Q0.16 ramp quotient, and the output register. A stall on the
// output holds the pipeline only where an item waits to move; empty stages
// keep filling. Registers are to be written with i_cfg_we / i_cfg_index /
// i_cfg_data while no item is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module adsr_envelope_gain (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [aeg_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [aeg_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  aeg_pkg::t_in_item                 i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output aeg_pkg::t_out_item                o_out_item
);

    aeg_pkg::t_cfg      r_cfg;
    logic               fr_valid, fr_stall;
    aeg_pkg::t_div_item fr_item;
    logic               dv_valid, dv_stall;
    aeg_pkg::t_div_item dv_item;

    // Configuration registers; values are masked to register width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.attack_length  <= aeg_pkg::RST_LENGTH;
            r_cfg.attack_level   <= aeg_pkg::RST_LEVEL;
            r_cfg.decay_length   <= aeg_pkg::RST_LENGTH;
            r_cfg.sustain_level  <= aeg_pkg::RST_LEVEL;
            r_cfg.release_length <= aeg_pkg::RST_LENGTH;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                aeg_pkg::CFG_ATTACK_LENGTH:
                    r_cfg.attack_length  <= i_cfg_data[aeg_pkg::LEN_W-1:0];
                aeg_pkg::CFG_ATTACK_LEVEL:
                    r_cfg.attack_level   <= i_cfg_data[aeg_pkg::GAIN_W-1:0];
                aeg_pkg::CFG_DECAY_LENGTH:
                    r_cfg.decay_length   <= i_cfg_data[aeg_pkg::LEN_W-1:0];
                aeg_pkg::CFG_SUSTAIN_LEVEL:
                    r_cfg.sustain_level  <= i_cfg_data[aeg_pkg::GAIN_W-1:0];
                aeg_pkg::CFG_RELEASE_LENGTH:
                    r_cfg.release_length <= i_cfg_data[aeg_pkg::LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    aeg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (i_in_item),
        .o_valid (fr_valid),
        .i_stall (fr_stall),
        .o_item  (fr_item)
    );

    aeg_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .o_stall (fr_stall),
        .i_item  (fr_item),
        .o_valid (dv_valid),
        .i_stall (dv_stall),
        .o_item  (dv_item)
    );

    aeg_output u_output (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dv_valid),
        .o_stall (dv_stall),
        .i_item  (dv_item),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (o_out_item)
    );

endmodule

// ----- sv/aeg_checker.sv -----
// ----------------------------------------------------------------------------
// aeg_checker
// Port-level checks of the envelope gain block, bound to the top level.
// ----------------------------------------------------------------------------
module aeg_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_cfg_we,
    input logic [aeg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input logic [aeg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input aeg_pkg::t_out_item             o_out_item
);

    logic [aeg_pkg::GAIN_W-1:0] r_sustain;

    // Track the sustain level as written on the port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sustain <= aeg_pkg::RST_LEVEL;
        end else if (i_cfg_we && i_cfg_index == aeg_pkg::CFG_SUSTAIN_LEVEL) begin
            r_sustain <= i_cfg_data[aeg_pkg::GAIN_W-1:0];
        end
    end

    // Hold a stalled result item
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result item changed or dropped");

    // Empty output means the pipeline can take an item
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled while output stage is empty");

    // Silent phases give zero gain
    a_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.phase == aeg_pkg::PH_WAIT ||
                        o_out_item.phase == aeg_pkg::PH_DONE)
        |-> o_out_item.gain == '0)
        else $error("nonzero gain before start or after release end");

    // Sustain holds the programmed level
    a_sustain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.phase == aeg_pkg::PH_SUSTAIN
        |-> o_out_item.gain == r_sustain)
        else $error("sustain gain differs from sustain level");

endmodule

bind adsr_envelope_gain aeg_checker u_aeg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_index (i_cfg_index),
    .i_cfg_data  (i_cfg_data),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

// ----- test/tb_adsr_envelope_gain.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adsr_envelope_gain
// Self-checking bench for the linear ADSR envelope gain pipeline.
// ----------------------------------------------------------------------------
// A short scripted table covers the reset settings, the field extremes and
// the corner cases of the envelope: release during attack or decay, release
// in the future, zero lengths and an upward decay. Random phases follow, each
// under its own register setting, with items aimed at the phase boundaries
// plus some raw noise. Every accepted item is run through a local envelope
// calculator and each result item is compared in order against it. Both
// handshake sides idle at random, except for one steady phase.
// ----------------------------------------------------------------------------
module tb_adsr_envelope_gain;

    localparam int          PIPE_LAT        = 20;
    localparam int          N_PHASES        = 12;
    localparam int          ITEMS_PER_PHASE = 111;
    localparam int          STEADY_PHASE    = 5;
    localparam int          HOLD_PHASE      = 7;
    localparam int          TIMEOUT_NS      = 2_000_000;
    localparam int          N_ROWS          = 26;

    // Indexes past the register list; writes there must be ignored
    localparam logic [aeg_pkg::CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd5;
    localparam logic [aeg_pkg::CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

    logic                               i_clk       = 1'b0;
    logic                               i_rst_n     = 1'b0;
    logic                               i_cfg_we    = 1'b0;
    logic [aeg_pkg::CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [aeg_pkg::CFG_DATA_W-1:0]     i_cfg_data  = '0;
    logic                               i_in_valid  = 1'b0;
    logic                               o_in_stall;
    aeg_pkg::t_in_item                  i_in_item   = '0;
    logic                               o_out_valid;
    logic                               i_out_stall = 1'b0;
    aeg_pkg::t_out_item                 o_out_item;

    // Register mirror, reset values
    logic [aeg_pkg::LEN_W-1:0]  cfg_attack_length  = aeg_pkg::RST_LENGTH;
    logic [aeg_pkg::GAIN_W-1:0] cfg_attack_level   = aeg_pkg::RST_LEVEL;
    logic [aeg_pkg::LEN_W-1:0]  cfg_decay_length   = aeg_pkg::RST_LENGTH;
    logic [aeg_pkg::GAIN_W-1:0] cfg_sustain_level  = aeg_pkg::RST_LEVEL;
    logic [aeg_pkg::LEN_W-1:0]  cfg_release_length = aeg_pkg::RST_LENGTH;

    aeg_pkg::t_out_item     gain_expected [$];
    int                     errors = 0;
    bit                     steady = 1'b0;

    // One scripted row: either a register write or an item
    typedef struct {
        bit                                 is_cfg;
        logic [aeg_pkg::CFG_IDX_W-1:0]      idx;
        logic [aeg_pkg::CFG_DATA_W-1:0]     data;
        logic [aeg_pkg::TIME_W-1:0]         el;
        bit                                 rel;
        logic [aeg_pkg::TIME_W-1:0]         rm;
        bit                                 fixed;
        logic [aeg_pkg::GAIN_W-1:0]         gain;
        aeg_pkg::t_phase                    ph;
    } t_row;

    t_row script [N_ROWS] = '{
        // reset settings: zero lengths, full levels
        '{1'b0, '0, '0, 32'h8000_0000, 1'b0, 32'h0000_0000, 1'b1, 16'd0, aeg_pkg::PH_WAIT},
        '{1'b0, '0, '0, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000, 1'b1, 16'd0, aeg_pkg::PH_WAIT},
        '{1'b0, '0, '0, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b1, 16'hFFFF, aeg_pkg::PH_SUSTAIN},
        '{1'b0, '0, '0, 32'h7FFF_FFFF, 1'b0, 32'h7FFF_FFFF, 1'b1, 16'hFFFF, aeg_pkg::PH_SUSTAIN},
        '{1'b0, '0, '0, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 1'b1, 16'd0, aeg_pkg::PH_DONE},
        '{1'b0, '0, '0, 32'd5,         1'b1, 32'd6,         1'b1, 16'hFFFF, aeg_pkg::PH_SUSTAIN},
        '{1'b0, '0, '0, 32'd5,         1'b1, 32'h8000_0000, 1'b1, 16'd0, aeg_pkg::PH_DONE},
        // attack 100 to 20000, decay 64 upward to 50000, release 300
        '{1'b1, aeg_pkg::CFG_ATTACK_LENGTH, 24'd100, '0, 1'b0, '0, 1'b0, '0, aeg_pkg::PH_WAIT},
        '{1'b1, aeg_pkg::CFG_ATTACK_LEVEL, 24'hFF_4E20, '0, 1'b0, '0, 1'b0, '0, aeg_pkg::PH_WAIT},
        '{1'b1, aeg_pkg::CFG_DECAY_LENGTH, 24'd64, '0, 1'b0, '0, 1'b0, '0, aeg_pkg::PH_WAIT},
        '{1'b1, aeg_pkg::CFG_SUSTAIN_LEVEL, 24'h00_C350, '0, 1'b0, '0, 1'b0, '0, aeg_pkg::PH_WAIT},
        '{1'b1, aeg_pkg::CFG_RELEASE_LENGTH, 24'd300, '0, 1'b0, '0, 1'b0, '0, aeg_pkg::PH_WAIT},
        '{1'b1, CFG_UNUSED_LO, 24'd0, '0, 1'b0, '0, 1'b0, '0, aeg_pkg::PH_WAIT},
        '{1'b1, CFG_UNUSED_HI, 24'hFF_FFFF, '0, 1'b0, '0, 1'b0, '0, aeg_pkg::PH_WAIT},
        '{1'b0, '0, '0, 32'd0,         1'b0, 32'd0,         1'b0, '0, aeg_pkg::PH_WAIT},
        '{1'b0, '0, '0, 32'd50,        1'b1, 32'd10,        1'b0, '0, aeg_pkg::PH_WAIT},
        '{1'b0, '0, '0, 32'd99,        1'b0, 32'd0,         1'b0, '0, aeg_pkg::PH_WAIT},
        '{1'b0, '0, '0, 32'd100,       1'b0, 32'd0,         1'b1, 16'd20000, aeg_pkg::PH_DECAY},
        '{1'b0, '0, '0, 32'd131,       1'b0, 32'd0,         1'b0, '0, aeg_pkg::PH_WAIT},
        '{1'b0, '0, '0, 32'd163,       1'b1, 32'd120,       1'b0, '0, aeg_pkg::PH_WAIT},
        '{1'b0, '0, '0, 32'd164,       1'b0, 32'd0,         1'b1, 16'd50000, aeg_pkg::PH_SUSTAIN},
        '{1'b0, '0, '0, 32'd164,       1'b1, 32'd100,       1'b0, '0, aeg_pkg::PH_WAIT},
        '{1'b0, '0, '0, 32'd400,       1'b1, 32'd100,       1'b1, 16'd0, aeg_pkg::PH_DONE},
        '{1'b0, '0, '0, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000, 1'b1, 16'd0, aeg_pkg::PH_DONE},
        '{1'b0, '0, '0, 32'd1000,      1'b1, 32'd999,       1'b0, '0, aeg_pkg::PH_WAIT},
        '{1'b0, '0, '0, 32'd1000,      1'b1, 32'h7FFF_FFFF, 1'b0, '0, aeg_pkg::PH_WAIT}
    };

    adsr_envelope_gain dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always #5 i_clk = ~i_clk;

    // Envelope gain and phase for one item under the mirrored registers
    function automatic aeg_pkg::t_out_item envelope_gain_of(input aeg_pkg::t_in_item it);
        aeg_pkg::t_out_item res;
        aeg_pkg::t_phase    ph;
        longint     t;
        longint     rm;
        longint     alen;
        longint     alvl;
        longint     dlen;
        longint     slvl;
        longint     rlen;
        longint     gain;
        t    = longint'($signed(it.elapsed));
        rm   = longint'($signed(it.release_moment));
        alen = longint'(cfg_attack_length);
        alvl = longint'(cfg_attack_level);
        dlen = longint'(cfg_decay_length);
        slvl = longint'(cfg_sustain_level);
        rlen = longint'(cfg_release_length);
        if (t < 0) begin
            gain = 0;
            ph   = aeg_pkg::PH_WAIT;
        end else if (t < alen) begin
            gain = (alvl * t) / alen;
            ph   = aeg_pkg::PH_ATTACK;
        end else if (t - alen < dlen) begin
            // signed quotient truncates toward zero when the decay rises
            gain = alvl - ((alvl - slvl) * (t - alen)) / dlen;
            ph   = aeg_pkg::PH_DECAY;
        end else if (!it.released || t < rm) begin
            gain = slvl;
            ph   = aeg_pkg::PH_SUSTAIN;
        end else if (t - rm < rlen) begin
            gain = slvl - (slvl * (t - rm)) / rlen;
            ph   = aeg_pkg::PH_RELEASE;
        end else begin
            gain = 0;
            ph   = aeg_pkg::PH_DONE;
        end
        if (gain < 0) begin
            gain = 0;
        end
        if (gain > 65535) begin
            gain = 65535;
        end
        res.gain  = gain[aeg_pkg::GAIN_W-1:0];
        res.phase = ph;
        return res;
    endfunction

    function automatic logic [aeg_pkg::LEN_W-1:0] random_length();
        logic [31:0] w;
        case ($urandom_range(3, 0))
            0: w = '0;
            1: w = $urandom_range(16, 1);
            2: w = $urandom_range(2000, 1);
            default: w = $urandom;
        endcase
        return w[aeg_pkg::LEN_W-1:0];
    endfunction

    // Level with random junk above bit 15, which the block must mask off
    function automatic logic [aeg_pkg::CFG_DATA_W-1:0] random_level();
        logic [31:0]                w;
        logic [aeg_pkg::GAIN_W-1:0] lvl;
        w = $urandom;
        case ($urandom_range(3, 0))
            0: lvl = '0;
            1: lvl = '1;
            default: lvl = w[aeg_pkg::GAIN_W-1:0];
        endcase
        return {w[23:16], lvl};
    endfunction

    // Item aimed mostly at the phase boundaries of the current setting
    function automatic aeg_pkg::t_in_item random_envelope_item();
        aeg_pkg::t_in_item it;
        longint     a_end;
        longint     d_end;
        longint     rlen;
        longint     el;
        longint     r;
        longint     rmt;
        a_end = longint'(cfg_attack_length);
        d_end = a_end + longint'(cfg_decay_length);
        rlen  = longint'(cfg_release_length);
        if ($urandom_range(99, 0) < 12) begin
            it.elapsed        = $urandom;
            it.released       = ($urandom_range(1, 0) != 0);
            it.release_moment = $urandom;
            return it;
        end
        case ($urandom_range(5, 0))
            0: el = longint'($urandom_range(8, 0)) - 4;
            1: el = a_end + longint'($urandom_range(8, 0)) - 4;
            2: el = d_end + longint'($urandom_range(8, 0)) - 4;
            3: el = longint'($urandom_range(32'(d_end + 8), 0));
            4: el = d_end + longint'($urandom_range(32'(2 * rlen + 8), 0));
            default: el = longint'($urandom_range(32'h7FFF_FFFF, 0));
        endcase
        case ($urandom_range(3, 0))
            0: r = longint'($urandom_range(32'(rlen + 4), 0));
            1: r = rlen + longint'($urandom_range(8, 0)) - 4;
            2: r = -longint'($urandom_range(100, 1));
            default: r = el - longint'($signed($urandom));
        endcase
        rmt               = el - r;
        it.elapsed        = el[aeg_pkg::TIME_W-1:0];
        it.released       = ($urandom_range(9, 0) != 0);
        it.release_moment = rmt[aeg_pkg::TIME_W-1:0];
        return it;
    endfunction

    // Drive one register write; caller lowers the enable after a burst
    task automatic write_register(input logic [aeg_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [aeg_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            aeg_pkg::CFG_ATTACK_LENGTH:  cfg_attack_length  = data[aeg_pkg::LEN_W-1:0];
            aeg_pkg::CFG_ATTACK_LEVEL:   cfg_attack_level   = data[aeg_pkg::GAIN_W-1:0];
            aeg_pkg::CFG_DECAY_LENGTH:   cfg_decay_length   = data[aeg_pkg::LEN_W-1:0];
            aeg_pkg::CFG_SUSTAIN_LEVEL:  cfg_sustain_level  = data[aeg_pkg::GAIN_W-1:0];
            aeg_pkg::CFG_RELEASE_LENGTH: cfg_release_length = data[aeg_pkg::LEN_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Register setting for one random phase; the first few are the extremes
    task automatic apply_setting(input int ph);
        logic [31:0] junk;
        case (ph)
            0: begin
                write_register(aeg_pkg::CFG_ATTACK_LENGTH, '1);
                write_register(aeg_pkg::CFG_ATTACK_LEVEL, '1);
                write_register(aeg_pkg::CFG_DECAY_LENGTH, '1);
                write_register(aeg_pkg::CFG_SUSTAIN_LEVEL, 24'hFF_0000);
                write_register(aeg_pkg::CFG_RELEASE_LENGTH, '1);
            end
            1: begin
                write_register(aeg_pkg::CFG_ATTACK_LENGTH, '0);
                write_register(aeg_pkg::CFG_ATTACK_LEVEL, 24'hAB_0000);
                write_register(aeg_pkg::CFG_DECAY_LENGTH, '0);
                write_register(aeg_pkg::CFG_SUSTAIN_LEVEL, 24'h00_FFFF);
                write_register(aeg_pkg::CFG_RELEASE_LENGTH, '0);
            end
            2: begin
                write_register(aeg_pkg::CFG_ATTACK_LENGTH, 24'd1);
                write_register(aeg_pkg::CFG_ATTACK_LEVEL, 24'd1);
                write_register(aeg_pkg::CFG_DECAY_LENGTH, 24'd1);
                write_register(aeg_pkg::CFG_SUSTAIN_LEVEL, 24'h00_FFFF);
                write_register(aeg_pkg::CFG_RELEASE_LENGTH, 24'd1);
            end
            default: begin
                write_register(aeg_pkg::CFG_ATTACK_LENGTH, random_length());
                write_register(aeg_pkg::CFG_ATTACK_LEVEL, random_level());
                write_register(aeg_pkg::CFG_DECAY_LENGTH, random_length());
                write_register(aeg_pkg::CFG_SUSTAIN_LEVEL, random_level());
                write_register(aeg_pkg::CFG_RELEASE_LENGTH, random_length());
            end
        endcase
        if ($urandom_range(1, 0) != 0) begin
            junk = $urandom;
            write_register($urandom_range(1, 0) ? CFG_UNUSED_LO : CFG_UNUSED_HI,
                           junk[aeg_pkg::CFG_DATA_W-1:0]);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Offer one item, hold it through stalls, queue its expected result.
    // Entered and left at a falling edge.
    task automatic send_envelope_item(input aeg_pkg::t_in_item it, input bit fixed,
                                      input aeg_pkg::t_out_item fixed_res);
        aeg_pkg::t_out_item res;
        while (!steady && $urandom_range(99, 0) < 16) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_item  <= it;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) begin
            @(posedge i_clk);
        end
        res = fixed ? fixed_res : envelope_gain_of(it);
        gain_expected.push_back(res);
        @(negedge i_clk);
    endtask

    // Stop sending, wait out every pending result and the pipeline tail
    task automatic wait_all_results();
        i_in_valid <= 1'b0;
        while (gain_expected.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (PIPE_LAT + 4) @(negedge i_clk);
    endtask

    // Random back-pressure on the result side
    always @(negedge i_clk) begin
        i_out_stall <= !steady && ($urandom_range(99, 0) < 16);
    end

    // Compare each accepted result item with the oldest expectation
    always @(posedge i_clk) begin
        aeg_pkg::t_out_item want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (gain_expected.size() == 0) begin
                $error("unexpected result item: gain %0d, phase %0d",
                       o_out_item.gain, o_out_item.phase);
                errors++;
            end else begin
                want = gain_expected.pop_front();
                if (o_out_item.gain !== want.gain) begin
                    $error("gain: expected %0d, actual %0d", want.gain, o_out_item.gain);
                    errors++;
                end
                if (o_out_item.phase !== want.phase) begin
                    $error("phase: expected %0d, actual %0d", want.phase, o_out_item.phase);
                    errors++;
                end
            end
        end
    end

    initial begin
        bit                 cfg_open;
        aeg_pkg::t_in_item  it;
        aeg_pkg::t_out_item res;
        cfg_open = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the scripted table
        for (int i = 0; i < N_ROWS; i++) begin
            if (script[i].is_cfg) begin
                if (!cfg_open) begin
                    wait_all_results();
                end
                write_register(script[i].idx, script[i].data);
                cfg_open = 1'b1;
            end else begin
                if (cfg_open) begin
                    i_cfg_we <= 1'b0;
                    cfg_open = 1'b0;
                end
                it.elapsed        = script[i].el;
                it.released       = script[i].rel;
                it.release_moment = script[i].rm;
                res.gain          = script[i].gain;
                res.phase         = script[i].ph;
                send_envelope_item(it, script[i].fixed, res);
            end
        end

        // Random phases, one register setting each
        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_all_results();
            apply_setting(ph);
            steady = (ph == STEADY_PHASE);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (ph == HOLD_PHASE && k == ITEMS_PER_PHASE / 2) begin
                    wait_all_results();
                end
                send_envelope_item(random_envelope_item(), 1'b0, '0);
            end
        end

        wait_all_results();
        if (errors == 0) begin
            $display("adsr_envelope_gain: match");
        end else begin
            $display("adsr_envelope_gain: mismatch");
        end
        $finish;
    end

    // Hard stop if the handshake hangs
    initial begin
        #(TIMEOUT_NS);
        $display("adsr_envelope_gain: mismatch");
        $finish;
    end

endmodule
